// ----- hw/rtl/ape_pkg.sv -----
// Shared types, constants and helpers for the arc point evaluator.
// Used by every cell and by the top level; depends on nothing.
`default_nettype none

package ape_pkg;

  // Angle constants in Q16 radians, and the CORDIC gain in Q30
  localparam logic signed [19:0] TWO_PI_Q16  = 20'sd411775;
  localparam logic signed [19:0] PI_Q16      = 20'sd205887;
  localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;
  localparam logic signed [32:0] GAIN_Q30    = 33'sd652032874;

  // Angle reduction: a multiple of 2pi at or above 2^43 keeps headings non-negative
  localparam int unsigned MOD_W      = 45;
  localparam int unsigned MOD_STAGES = 27;
  localparam logic [MOD_W-1:0] MOD_OFFSET = MOD_W'(64'd411775 * 64'd21361407);

  // Quotient bits of the arc divider: 33-bit magnitude shifted up by 20
  localparam int unsigned DIV_BITS = 53;

  localparam logic signed [65:0] MIN32 = -66'sd2147483648;
  localparam logic signed [65:0] MAX32 = 66'sd2147483647;

  localparam logic [29:0] ATAN_Q30 [30] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
    30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
    30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
    30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255,
    30'd127, 30'd63, 30'd31, 30'd15, 30'd7, 30'd3, 30'd1
  };

  typedef enum logic [7:0] {
    REG_START_X       = 8'd0,
    REG_START_Y       = 8'd1,
    REG_START_HEADING = 8'd2,
    REG_CURVATURE     = 8'd3
  } cfg_reg_e;

  typedef struct packed {
    logic signed [31:0] s;
    logic signed [31:0] off;
    logic signed [43:0] h;
  } side_a_t;

  typedef struct packed {
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [32:0] z;
    logic               neg;
  } cordic_t;

  typedef struct packed {
    logic [31:0]         rem;
    logic [DIV_BITS-1:0] nq;
    logic                neg;
  } div_t;

  typedef struct packed {
    logic signed [31:0] heading;
    logic signed [17:0] tan_x;
    logic signed [17:0] tan_y;
    logic signed [31:0] sec_x;
    logic signed [31:0] sec_y;
    logic               sat;
    logic signed [35:0] line_x;
    logic signed [35:0] line_y;
    logic signed [35:0] off_x;
    logic signed [35:0] off_y;
  } side_b_t;

  typedef struct packed {
    logic signed [31:0] val;
    logic               sat;
  } sat32_t;

  typedef struct packed {
    logic signed [32:0] z;
    logic               neg;
  } fold_t;

  function automatic sat32_t clip32(input logic signed [65:0] v);
    sat32_t r;
    r.sat = 1'b0;
    if (v < MIN32) begin
      r.val = 32'sh8000_0000;
      r.sat = 1'b1;
    end else if (v > MAX32) begin
      r.val = 32'sh7fff_ffff;
      r.sat = 1'b1;
    end else begin
      r.val = v[31:0];
    end
    return r;
  endfunction

  // Map a reduced angle in [0, 2pi) to [-pi/2, pi/2] in Q30, noting a half turn
  function automatic fold_t fold_angle(input logic [18:0] r);
    logic signed [19:0] a;
    fold_t f;
    a = signed'({1'b0, r});
    f.neg = 1'b0;
    if (a > PI_Q16) a = a - TWO_PI_Q16;
    if (a > HALF_PI_Q16) begin
      a = a - PI_Q16;
      f.neg = 1'b1;
    end else if (a < -HALF_PI_Q16) begin
      a = a + PI_Q16;
      f.neg = 1'b1;
    end
    f.z = 33'(a) <<< 14;
    return f;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ape_mod_cell.sv -----
// One compare-subtract step of the 2pi angle reduction, two lanes.
// Uses ape_pkg for widths and side data types.
`default_nettype none

module ape_mod_cell import ape_pkg::*; #(
  parameter int unsigned J = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [MOD_W-1:0] u_h_i,
  input  logic [MOD_W-1:0] u_0_i,
  input  side_a_t          side_i,
  output logic             valid_o,
  output logic [MOD_W-1:0] u_h_o,
  output logic [MOD_W-1:0] u_0_o,
  output side_a_t          side_o
);

  localparam logic [MOD_W-1:0] Sub = MOD_W'(TWO_PI_Q16) << J;

  logic             valid_q;
  logic [MOD_W-1:0] u_h_q, u_0_q, u_h_d, u_0_d;
  side_a_t          side_q;

  assign u_h_d = (u_h_i >= Sub) ? u_h_i - Sub : u_h_i;
  assign u_0_d = (u_0_i >= Sub) ? u_0_i - Sub : u_0_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else         valid_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    u_h_q  <= u_h_d;
    u_0_q  <= u_0_d;
    side_q <= side_i;
  end

  assign valid_o = valid_q;
  assign u_h_o   = u_h_q;
  assign u_0_o   = u_0_q;
  assign side_o  = side_q;

endmodule

`default_nettype wire

// ----- hw/rtl/ape_cordic_cell.sv -----
// One CORDIC rotation step for the heading lane and the start heading lane.
// Uses ape_pkg for the arctangent table and lane types.
`default_nettype none

module ape_cordic_cell import ape_pkg::*; #(
  parameter int unsigned I = 0
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  input  cordic_t lane_h_i,
  input  cordic_t lane_0_i,
  input  side_a_t side_i,
  output logic    valid_o,
  output cordic_t lane_h_o,
  output cordic_t lane_0_o,
  output side_a_t side_o
);

  localparam logic signed [32:0] Atan = 33'(ATAN_Q30[I]);

  function automatic cordic_t rotate(input cordic_t a);
    cordic_t r;
    logic signed [32:0] dx, dy;
    dx = a.y >>> I;
    dy = a.x >>> I;
    r = a;
    if (a.z >= 0) begin
      r.x = a.x - dx;
      r.y = a.y + dy;
      r.z = a.z - Atan;
    end else begin
      r.x = a.x + dx;
      r.y = a.y - dy;
      r.z = a.z + Atan;
    end
    return r;
  endfunction

  logic    valid_q;
  cordic_t lane_h_q, lane_0_q;
  side_a_t side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else         valid_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    lane_h_q <= rotate(lane_h_i);
    lane_0_q <= rotate(lane_0_i);
    side_q   <= side_i;
  end

  assign valid_o  = valid_q;
  assign lane_h_o = lane_h_q;
  assign lane_0_o = lane_0_q;
  assign side_o   = side_q;

endmodule

`default_nettype wire

// ----- hw/rtl/ape_div_cell.sv -----
// One quotient bit of the restoring divider, x and y lanes share the divisor.
// Uses ape_pkg for lane and side data types.
`default_nettype none

module ape_div_cell import ape_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [31:0] divisor_i,
  input  div_t        lane_x_i,
  input  div_t        lane_y_i,
  input  side_b_t     side_i,
  output logic        valid_o,
  output div_t        lane_x_o,
  output div_t        lane_y_o,
  output side_b_t     side_o
);

  function automatic div_t step(input div_t a, input logic [31:0] d);
    div_t r;
    logic [32:0] t;
    logic        b;
    t = {a.rem, a.nq[DIV_BITS-1]};
    b = (t >= {1'b0, d});
    r.neg = a.neg;
    r.rem = b ? 32'(t - {1'b0, d}) : t[31:0];
    r.nq  = {a.nq[DIV_BITS-2:0], b};
    return r;
  endfunction

  logic    valid_q;
  div_t    lane_x_q, lane_y_q;
  side_b_t side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else         valid_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    lane_x_q <= step(lane_x_i, divisor_i);
    lane_y_q <= step(lane_y_i, divisor_i);
    side_q   <= side_i;
  end

  assign valid_o  = valid_q;
  assign lane_x_o = lane_x_q;
  assign lane_y_o = lane_y_q;
  assign side_o   = side_q;

endmodule

`default_nettype wire

// ----- hw/rtl/arc_point_evaluator.sv -----
// Top level of the arc point evaluator: config registers, glue stages and the cell chains.
// Depends on ape_pkg, ape_mod_cell, ape_cordic_cell and ape_div_cell.
//
//   channel | handshake                    | payload
//   --------+------------------------------+------------------------------------------
//   input   | start_i, busy_o              | arc_pos_i, lateral_offset_i
//   config  | cfg_valid_i, cfg_ready_o     | cfg_index_i, cfg_data_i
//   result  | result_valid_o (strobe)      | pos_x_o .. shifted_y_o, saturated_o
//
// A new word is taken every cycle; busy_o stays low.
// The pipeline holds 27 angle reduction cells, one CORDIC cell per
// step, 53 divider cells (one quotient bit each) and 8 glue and output stages.
// Reset clears the config registers to zero and empties the pipeline.
// Results come out in order on a one-cycle strobe; the receiver cannot stall.
`default_nettype none

module arc_point_evaluator import ape_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = 18
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [31:0] arc_pos_i,
  input  logic signed [31:0] lateral_offset_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output logic               result_valid_o,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] heading_o,
  output logic signed [17:0] tangent_x_o,
  output logic signed [17:0] tangent_y_o,
  output logic signed [31:0] second_x_o,
  output logic signed [31:0] second_y_o,
  output logic signed [31:0] shifted_x_o,
  output logic signed [31:0] shifted_y_o,
  output logic               saturated_o
);

  localparam int unsigned Latency = MOD_STAGES + DIV_BITS + CORDIC_STEPS + 8;

  // ---------------- configuration ----------------
  logic signed [31:0] start_x_q, start_y_q, start_heading_q, curvature_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q       <= '0;
      start_y_q       <= '0;
      start_heading_q <= '0;
      curvature_q     <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_START_X:       start_x_q       <= cfg_data_i;
        REG_START_Y:       start_y_q       <= cfg_data_i;
        REG_START_HEADING: start_heading_q <= cfg_data_i;
        REG_CURVATURE:     curvature_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic        k_zero;
  logic [31:0] k_mag;
  assign k_zero = (curvature_q == '0);
  assign k_mag  = curvature_q[31] ? 32'(-curvature_q) : curvature_q;

  // ---------------- stage 1: s * k ----------------
  logic               v1_q;
  logic signed [31:0] s1_s_q, s1_off_q;
  logic signed [63:0] s1_sk_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else         v1_q <= start_i && !busy_o;
  end

  always_ff @(posedge clk_i) begin
    s1_s_q   <= arc_pos_i;
    s1_off_q <= lateral_offset_i;
    s1_sk_q  <= arc_pos_i * curvature_q;
  end

  // ---------------- stage 2: heading, offset for reduction ----------------
  logic               v2_q;
  logic signed [63:0] sk_rnd;
  logic signed [43:0] h_d;
  logic [MOD_W-1:0]   u_h_q, u_0_q;
  side_a_t            side2_q;

  assign sk_rnd = (s1_sk_q + 64'sd524288) >>> 20;
  assign h_d    = 44'(start_heading_q) + 44'(sk_rnd);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else         v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    u_h_q       <= MOD_W'(h_d) + MOD_OFFSET;
    u_0_q       <= MOD_W'(start_heading_q) + MOD_OFFSET;
    side2_q.s   <= s1_s_q;
    side2_q.off <= s1_off_q;
    side2_q.h   <= h_d;
  end

  // ---------------- 2pi reduction chain ----------------
  logic             mod_v [0:MOD_STAGES];
  logic [MOD_W-1:0] mod_h [0:MOD_STAGES];
  logic [MOD_W-1:0] mod_0 [0:MOD_STAGES];
  side_a_t          mod_s [0:MOD_STAGES];

  assign mod_v[0] = v2_q;
  assign mod_h[0] = u_h_q;
  assign mod_0[0] = u_0_q;
  assign mod_s[0] = side2_q;

  for (genvar g = 0; g < MOD_STAGES; g++) begin : g_mod
    ape_mod_cell #(.J(MOD_STAGES - 1 - g)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (mod_v[g]),
      .u_h_i   (mod_h[g]),
      .u_0_i   (mod_0[g]),
      .side_i  (mod_s[g]),
      .valid_o (mod_v[g+1]),
      .u_h_o   (mod_h[g+1]),
      .u_0_o   (mod_0[g+1]),
      .side_o  (mod_s[g+1])
    );
  end

  // ---------------- fold into +-pi/2 ----------------
  logic    vf_q;
  fold_t   fold_h, fold_0;
  cordic_t cin_h_q, cin_0_q;
  side_a_t sidef_q;

  assign fold_h = fold_angle(mod_h[MOD_STAGES][18:0]);
  assign fold_0 = fold_angle(mod_0[MOD_STAGES][18:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vf_q <= 1'b0;
    else         vf_q <= mod_v[MOD_STAGES];
  end

  always_ff @(posedge clk_i) begin
    cin_h_q <= '{x: GAIN_Q30, y: '0, z: fold_h.z, neg: fold_h.neg};
    cin_0_q <= '{x: GAIN_Q30, y: '0, z: fold_0.z, neg: fold_0.neg};
    sidef_q <= mod_s[MOD_STAGES];
  end

  // ---------------- CORDIC chain ----------------
  logic    cor_v [0:CORDIC_STEPS];
  cordic_t cor_h [0:CORDIC_STEPS];
  cordic_t cor_0 [0:CORDIC_STEPS];
  side_a_t cor_s [0:CORDIC_STEPS];

  assign cor_v[0] = vf_q;
  assign cor_h[0] = cin_h_q;
  assign cor_0[0] = cin_0_q;
  assign cor_s[0] = sidef_q;

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
    ape_cordic_cell #(.I(g)) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .valid_i  (cor_v[g]),
      .lane_h_i (cor_h[g]),
      .lane_0_i (cor_0[g]),
      .side_i   (cor_s[g]),
      .valid_o  (cor_v[g+1]),
      .lane_h_o (cor_h[g+1]),
      .lane_0_o (cor_0[g+1]),
      .side_o   (cor_s[g+1])
    );
  end

  // ---------------- P1: undo half turn ----------------
  logic               vp1_q;
  logic signed [32:0] ch_q, sh_q, c0_q, s0_q;
  side_a_t            sidep1_q;
  cordic_t            ce_h, ce_0;

  assign ce_h = cor_h[CORDIC_STEPS];
  assign ce_0 = cor_0[CORDIC_STEPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vp1_q <= 1'b0;
    else         vp1_q <= cor_v[CORDIC_STEPS];
  end

  always_ff @(posedge clk_i) begin
    ch_q     <= ce_h.neg ? -ce_h.x : ce_h.x;
    sh_q     <= ce_h.neg ? -ce_h.y : ce_h.y;
    c0_q     <= ce_0.neg ? -ce_0.x : ce_0.x;
    s0_q     <= ce_0.neg ? -ce_0.y : ce_0.y;
    sidep1_q <= cor_s[CORDIC_STEPS];
  end

  // ---------------- P2: products ----------------
  logic               vp2_q;
  logic signed [65:0] p_sch_q, p_ssh_q, p_ksh_q, p_kch_q, p_osh_q, p_och_q;
  logic signed [33:0] dnx_q, dny_q;
  logic signed [18:0] tx_q, ty_q;
  logic signed [43:0] h2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vp2_q <= 1'b0;
    else         vp2_q <= vp1_q;
  end

  always_ff @(posedge clk_i) begin
    p_sch_q <= sidep1_q.s * ch_q;
    p_ssh_q <= sidep1_q.s * sh_q;
    p_ksh_q <= curvature_q * sh_q;
    p_kch_q <= curvature_q * ch_q;
    p_osh_q <= sidep1_q.off * sh_q;
    p_och_q <= sidep1_q.off * ch_q;
    dnx_q   <= 34'(sh_q) - 34'(s0_q);
    dny_q   <= 34'(ch_q) - 34'(c0_q);
    tx_q    <= 19'((34'(ch_q) + 34'sd8192) >>> 14);
    ty_q    <= 19'((34'(sh_q) + 34'sd8192) >>> 14);
    h2_q    <= sidep1_q.h;
  end

  // ---------------- P3: rounding, clipping, divider setup ----------------
  function automatic logic signed [35:0] rnd30(input logic signed [65:0] p);
    logic signed [65:0] t;
    t = (p + 66'sd536870912) >>> 30;
    return t[35:0];
  endfunction

  function automatic logic [18:0] clip_tan(input logic signed [18:0] t);
    logic [18:0] r;
    if (t > 19'sd65536)       r = {1'b1, 18'sd65536};
    else if (t < -19'sd65536) r = {1'b1, -18'sd65536};
    else                      r = {1'b0, t[17:0]};
    return r;
  endfunction

  logic               vp3_q;
  logic signed [35:0] sec_x_r, sec_y_r;
  sat32_t             head_c, secx_c, secy_c;
  logic [18:0]        tanx_c, tany_c;
  logic [33:0]        mag_x, mag_y;
  side_b_t            sidep3_q;
  div_t               din_x_q, din_y_q;

  assign sec_x_r = rnd30(-p_ksh_q);
  assign sec_y_r = rnd30(p_kch_q);
  assign head_c  = clip32(66'(h2_q));
  assign secx_c  = clip32(66'(sec_x_r));
  assign secy_c  = clip32(66'(sec_y_r));
  assign tanx_c  = clip_tan(tx_q);
  assign tany_c  = clip_tan(ty_q);
  assign mag_x   = dnx_q[33] ? 34'(-dnx_q) : dnx_q;
  assign mag_y   = dny_q[33] ? 34'(-dny_q) : dny_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vp3_q <= 1'b0;
    else         vp3_q <= vp2_q;
  end

  always_ff @(posedge clk_i) begin
    sidep3_q.heading <= head_c.val;
    sidep3_q.tan_x   <= tanx_c[17:0];
    sidep3_q.tan_y   <= tany_c[17:0];
    sidep3_q.sec_x   <= secx_c.val;
    sidep3_q.sec_y   <= secy_c.val;
    sidep3_q.sat     <= head_c.sat | secx_c.sat | secy_c.sat | tanx_c[18] | tany_c[18];
    sidep3_q.line_x  <= rnd30(p_sch_q);
    sidep3_q.line_y  <= rnd30(p_ssh_q);
    sidep3_q.off_x   <= rnd30(-p_osh_q);
    sidep3_q.off_y   <= rnd30(p_och_q);
    din_x_q <= '{rem: '0, nq: {mag_x[32:0], 20'd0}, neg: dnx_q[33] ^ curvature_q[31]};
    din_y_q <= '{rem: '0, nq: {mag_y[32:0], 20'd0}, neg: dny_q[33] ^ curvature_q[31]};
  end

  // ---------------- divider chain ----------------
  logic    div_v [0:DIV_BITS];
  div_t    div_x [0:DIV_BITS];
  div_t    div_y [0:DIV_BITS];
  side_b_t div_s [0:DIV_BITS];

  assign div_v[0] = vp3_q;
  assign div_x[0] = din_x_q;
  assign div_y[0] = din_y_q;
  assign div_s[0] = sidep3_q;

  for (genvar g = 0; g < DIV_BITS; g++) begin : g_div
    ape_div_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .valid_i   (div_v[g]),
      .divisor_i (k_mag),
      .lane_x_i  (div_x[g]),
      .lane_y_i  (div_y[g]),
      .side_i    (div_s[g]),
      .valid_o   (div_v[g+1]),
      .lane_x_o  (div_x[g+1]),
      .lane_y_o  (div_y[g+1]),
      .side_o    (div_s[g+1])
    );
  end

  // ---------------- F1: centerline point ----------------
  logic               vf1_q;
  logic signed [54:0] qx_s, qy_s, qx_t, qy_t;
  logic signed [41:0] px_d, py_d, px_q, py_q;
  side_b_t            sidef1_q;
  div_t               dq_x, dq_y;

  assign dq_x = div_x[DIV_BITS];
  assign dq_y = div_y[DIV_BITS];
  assign qx_s = dq_x.neg ? -$signed({2'b00, dq_x.nq}) : $signed({2'b00, dq_x.nq});
  assign qy_s = dq_y.neg ? -$signed({2'b00, dq_y.nq}) : $signed({2'b00, dq_y.nq});
  assign qx_t = (qx_s + 55'sd8192) >>> 14;
  assign qy_t = (qy_s + 55'sd8192) >>> 14;

  always_comb begin
    if (k_zero) begin
      px_d = 42'(start_x_q) + 42'(div_s[DIV_BITS].line_x);
      py_d = 42'(start_y_q) + 42'(div_s[DIV_BITS].line_y);
    end else begin
      px_d = 42'(start_x_q) + 42'(qx_t);
      py_d = 42'(start_y_q) - 42'(qy_t);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vf1_q <= 1'b0;
    else         vf1_q <= div_v[DIV_BITS];
  end

  always_ff @(posedge clk_i) begin
    px_q     <= px_d;
    py_q     <= py_d;
    sidef1_q <= div_s[DIV_BITS];
  end

  // ---------------- F2: shifted point, clip, output register ----------------
  sat32_t px_c, py_c, shx_c, shy_c;
  logic   out_v_q;

  // shifted point is taken from the unclipped centerline
  assign px_c  = clip32(66'(px_q));
  assign py_c  = clip32(66'(py_q));
  assign shx_c = clip32(66'(43'(px_q) + 43'(sidef1_q.off_x)));
  assign shy_c = clip32(66'(43'(py_q) + 43'(sidef1_q.off_y)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else         out_v_q <= vf1_q;
  end

  always_ff @(posedge clk_i) begin
    pos_x_o     <= px_c.val;
    pos_y_o     <= py_c.val;
    heading_o   <= sidef1_q.heading;
    tangent_x_o <= sidef1_q.tan_x;
    tangent_y_o <= sidef1_q.tan_y;
    second_x_o  <= sidef1_q.sec_x;
    second_y_o  <= sidef1_q.sec_y;
    shifted_x_o <= shx_c.val;
    shifted_y_o <= shy_c.val;
    saturated_o <= sidef1_q.sat | px_c.sat | py_c.sat | shx_c.sat | shy_c.sat;
  end

  assign result_valid_o = out_v_q;

  // ---------------- assertions ----------------
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start_i, Latency))
    else $error("result word without a matching start");

  a_tan_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (tangent_x_o <= 18'sd65536) && (tangent_x_o >= -18'sd65536)
                    && (tangent_y_o <= 18'sd65536) && (tangent_y_o >= -18'sd65536))
    else $error("tangent outside unit range");

  a_straight : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && k_zero) |-> (second_x_o == '0) && (second_y_o == '0)
                                   && (heading_o == start_heading_q))
    else $error("straight segment gave curved terms");

endmodule

`default_nettype wire
